>>> hw/rtl/fsf_pkg.sv
// ----------------------------------------------------------------------------
// fsf_pkg: shared types and constants for the file name suffix filter
// Field widths, input word kinds, slot status codes and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package fsf_pkg;

  localparam int PATTERN_SLOTS_DEF = 8;
  localparam int PATTERN_MAX_DEF   = 32;
  localparam int NAME_MAX_DEF      = 255;

  localparam int KIND_W     = 2;
  localparam int SLOT_W     = 3;
  localparam int POS_W      = 5;
  localparam int CHAR_W     = 8;
  localparam int PLEN_W     = 6;
  localparam int SEC_W      = 32;
  localparam int NSEC_W     = 30;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CHAR_W-1:0] STAR_CHAR = 8'h2A;

  typedef enum logic [KIND_W-1:0] {
    KIND_PAT_CHAR  = 2'd0,
    KIND_PAT_LEN   = 2'd1,
    KIND_NAME_CHAR = 2'd2,
    KIND_NAME_END  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_PENDING = 3'b001,
    ST_MATCHED = 3'b010,
    ST_FAILED  = 3'b100
  } slot_st_t;

  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_ALL  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AGE_ENABLE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AGE_SEC    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_AGE_NSEC   = 3'd3;

endpackage

`default_nettype wire

>>> hw/rtl/fsf_if.sv
// ----------------------------------------------------------------------------
// fsf_if: channel interfaces of the file name suffix filter
// Input word channel, result channel and register write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface fsf_in_if;
  import fsf_pkg::*;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [SLOT_W-1:0] slot;
  logic [POS_W-1:0]  position;
  logic [CHAR_W-1:0] character;
  logic [PLEN_W-1:0] pattern_len;
  logic              slot_in_use;
  logic [SEC_W-1:0]  ctime_seconds;
  logic [NSEC_W-1:0] ctime_nanoseconds;
  logic              is_directory;

  modport source (output valid, kind, slot, position, character, pattern_len,
                  slot_in_use, ctime_seconds, ctime_nanoseconds, is_directory,
                  input ready);
  modport sink   (input valid, kind, slot, position, character, pattern_len,
                  slot_in_use, ctime_seconds, ctime_nanoseconds, is_directory,
                  output ready);
endinterface

interface fsf_out_if;
  logic valid;
  logic ready;
  logic matches_res;
  logic wildcard_misplaced;

  modport source (output valid, matches_res, wildcard_misplaced, input ready);
  modport sink   (input valid, matches_res, wildcard_misplaced, output ready);
endinterface

interface fsf_cfg_if;
  import fsf_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/filename_suffix_filter_core.sv
// ----------------------------------------------------------------------------
// filename_suffix_filter_core: multi-pattern suffix filter for file names
// Loads a table of suffix patterns, streams names last character first and
// reports one match decision per name.
// ----------------------------------------------------------------------------
// Usage:
//   in_if carries one word per handshake: a pattern character, a pattern
//   length/valid update, a name character (last character first) or an end
//   of name word with ctime and directory flag. Only end of name words give
//   a result word on out_if (matches_res, wildcard_misplaced).
//   cfg_if writes match_all, age_rule_enabled and the age limit; it is always
//   ready and should be written only while the block is idle.
// Timing:
//   One input word per cycle while the input is not stalled (see Stall).
//   Each slot's pattern store is read at acceptance (registered read port);
//   the slot status update and the result register are fed from the compare
//   stage registers; a result appears once its end of name word leaves it.
// Stall:
//   The result register holds until taken. Input words keep flowing while a
//   result waits; a second end of name word holds in the compare stage and
//   stalls the input until the waiting result is taken.
// Reset:
//   Synchronous, active low. Clears slot validity, lengths, name state and
//   control registers. Pattern characters stay undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module filename_suffix_filter_core #(
  parameter int PATTERN_SLOTS = fsf_pkg::PATTERN_SLOTS_DEF,
  parameter int PATTERN_MAX   = fsf_pkg::PATTERN_MAX_DEF,
  parameter int NAME_MAX      = fsf_pkg::NAME_MAX_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  fsf_in_if.sink   in_if,
  fsf_out_if.source out_if,
  fsf_cfg_if.sink  cfg_if
);

  import fsf_pkg::*;

  localparam int AW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int LW = $clog2(PATTERN_MAX + 1);
  localparam int NW = $clog2(NAME_MAX + 1);
  localparam int CW = ((LW > NW) ? LW : NW) + 1;
  localparam int PW = (LW > PLEN_W) ? LW : PLEN_W;
  localparam int QW = (LW > POS_W) ? LW : POS_W;

  // configuration
  logic              match_all_r;
  logic              age_en_r;
  logic [SEC_W-1:0]  age_sec_r;
  logic [NSEC_W-1:0] age_nsec_r;

  // table and name state
  logic [LW-1:0] len_r [PATTERN_SLOTS];
  logic          vld_r [PATTERN_SLOTS];
  logic [NW-1:0] cnt_r;

  // compare stage
  logic              s1_valid_r;
  logic              s1_cmp_r;
  logic              s1_end_r;
  logic              s1_age_r;
  logic [CHAR_W-1:0] s1_ch_r;
  logic              s1_ge_r  [PATTERN_SLOTS];
  logic              s1_eq_r  [PATTERN_SLOTS];
  logic              s1_pnz_r [PATTERN_SLOTS];
  logic              s1_vld_r [PATTERN_SLOTS];
  logic [CHAR_W-1:0] pc_w     [PATTERN_SLOTS];

  slot_st_t st_r   [PATTERN_SLOTS];
  slot_st_t st_nxt [PATTERN_SLOTS];
  logic     mis_r   [PATTERN_SLOTS];
  logic     mis_nxt [PATTERN_SLOTS];

  logic out_valid_r;
  logic out_hit_r;
  logic out_mis_r;

  logic pipe_en;
  logic in_acc;
  logic b_fire;
  logic kind_len;
  logic kind_char;
  logic kind_name;
  logic kind_end;
  logic name_room;
  logic pos_ok;
  logic age_older;
  logic [LW-1:0] len_sat;
  logic [PW-1:0] plen_ext;
  logic hit_any;
  logic mis_any;

  // ---------------- configuration ----------------
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_all_r <= 1'b0;
      age_en_r    <= 1'b0;
      age_sec_r   <= '0;
      age_nsec_r  <= '0;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        CFG_MATCH_ALL:  match_all_r <= cfg_if.data[0];
        CFG_AGE_ENABLE: age_en_r    <= cfg_if.data[0];
        CFG_AGE_SEC:    age_sec_r   <= cfg_if.data[SEC_W-1:0];
        CFG_AGE_NSEC:   age_nsec_r  <= cfg_if.data[NSEC_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- acceptance stage ----------------
  // a second end of name word waits only while the result register is full
  assign pipe_en     = !(s1_valid_r && s1_end_r && out_valid_r && !out_if.ready);
  assign in_if.ready = pipe_en;
  assign in_acc      = in_if.valid && pipe_en;
  assign b_fire      = s1_valid_r && pipe_en;

  always_comb begin
    kind_char = 1'b0;
    kind_len  = 1'b0;
    kind_name = 1'b0;
    kind_end  = 1'b0;
    case (kind_t'(in_if.kind))
      KIND_PAT_CHAR:  kind_char = 1'b1;
      KIND_PAT_LEN:   kind_len  = 1'b1;
      KIND_NAME_CHAR: kind_name = 1'b1;
      KIND_NAME_END:  kind_end  = 1'b1;
      default: ;
    endcase
  end

  assign name_room = cnt_r < NW'(NAME_MAX);
  assign pos_ok    = QW'(in_if.position) < QW'(PATTERN_MAX);
  assign plen_ext  = PW'(in_if.pattern_len);
  assign len_sat   = (plen_ext > PW'(PATTERN_MAX)) ? LW'(PATTERN_MAX) : LW'(plen_ext);
  assign age_older = (age_sec_r > in_if.ctime_seconds) ||
                     ((age_sec_r == in_if.ctime_seconds) &&
                      (age_nsec_r > in_if.ctime_nanoseconds));

  for (genvar s = 0; s < PATTERN_SLOTS; s++) begin : g_slot
    logic          sel;
    logic [CW-1:0] ptr;

    assign sel = int'(in_if.slot) == s;
    assign ptr = CW'(len_r[s]) - CW'(1) - CW'(cnt_r);

    fsf_slot_ram #(
      .DEPTH (PATTERN_MAX),
      .WIDTH (CHAR_W)
    ) u_ram (
      .clk   (clk),
      .we    (in_acc && kind_char && sel && pos_ok),
      .waddr (AW'(in_if.position)),
      .wdata (in_if.character),
      .re    (in_acc),
      .raddr (ptr[AW-1:0]),
      .rdata (pc_w[s])
    );

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        len_r[s] <= '0;
        vld_r[s] <= 1'b0;
      end else if (in_acc && kind_len && sel) begin
        len_r[s] <= len_sat;
        vld_r[s] <= in_if.slot_in_use;
      end
    end

    always_ff @(posedge clk) begin
      if (in_acc) begin
        s1_ge_r[s]  <= CW'(cnt_r) >= CW'(len_r[s]);
        s1_eq_r[s]  <= CW'(cnt_r) == CW'(len_r[s]);
        s1_pnz_r[s] <= ptr != '0;
        s1_vld_r[s] <= vld_r[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (in_acc && kind_end) begin
      cnt_r <= '0;
    end else if (in_acc && kind_name && name_room) begin
      cnt_r <= cnt_r + NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_cmp_r   <= 1'b0;
      s1_end_r   <= 1'b0;
    end else if (pipe_en) begin
      s1_valid_r <= in_acc;
      s1_cmp_r   <= in_acc && kind_name && name_room;
      s1_end_r   <= in_acc && kind_end;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_ch_r  <= in_if.character;
      s1_age_r <= age_en_r && (in_if.is_directory || age_older);
    end
  end

  // ---------------- compare stage ----------------
  always_comb begin
    for (int s = 0; s < PATTERN_SLOTS; s++) begin
      st_nxt[s]  = st_r[s];
      mis_nxt[s] = mis_r[s];
      if (b_fire) begin
        if (s1_end_r) begin
          st_nxt[s]  = ST_PENDING;
          mis_nxt[s] = 1'b0;
        end else if (s1_cmp_r && st_r[s] == ST_PENDING) begin
          if (s1_ge_r[s]) begin
            st_nxt[s] = ST_FAILED;
          end else if (pc_w[s] == STAR_CHAR) begin
            st_nxt[s]  = ST_MATCHED;
            mis_nxt[s] = s1_pnz_r[s];
          end else if (pc_w[s] != s1_ch_r) begin
            st_nxt[s] = ST_FAILED;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < PATTERN_SLOTS; s++) begin
        st_r[s]  <= ST_PENDING;
        mis_r[s] <= 1'b0;
      end
    end else begin
      for (int s = 0; s < PATTERN_SLOTS; s++) begin
        st_r[s]  <= st_nxt[s];
        mis_r[s] <= mis_nxt[s];
      end
    end
  end

  always_comb begin
    hit_any = s1_age_r;
    mis_any = 1'b0;
    for (int s = 0; s < PATTERN_SLOTS; s++) begin
      if (s1_vld_r[s]) begin
        if (st_r[s] == ST_MATCHED) begin
          hit_any = 1'b1;
          mis_any = mis_any || mis_r[s];
        end else if (st_r[s] == ST_PENDING && s1_eq_r[s]) begin
          hit_any = 1'b1;
        end
      end
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (b_fire && s1_end_r) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_fire && s1_end_r) begin
      out_hit_r <= hit_any || match_all_r;
      out_mis_r <= mis_any && !match_all_r;
    end
  end

  assign out_if.valid              = out_valid_r;
  assign out_if.matches_res        = out_hit_r;
  assign out_if.wildcard_misplaced = out_mis_r;

endmodule

`default_nettype wire

>>> hw/rtl/fsf_slot_ram.sv
// ----------------------------------------------------------------------------
// fsf_slot_ram: pattern character store of one slot
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fsf_slot_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 8,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
